[sv/prq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_pkg
// Shared constants and types for the priority ready queue insert block.
// ----------------------------------------------------------------------------
package prq_pkg;

    // Port field widths, fixed by the item layout
    localparam int TASK_W    = 4;
    localparam int IN_PRIO_W = 8;
    localparam int S_TDATA_W = 16;   // task_id + task_prio, padded to bytes
    localparam int M_TDATA_W = 16;   // result fields, padded to bytes

    // Defaults for the top-level parameters
    localparam int NUM_TASKS_DEF  = 16;
    localparam int PRIO_WIDTH_DEF = 8;

    // Result item, lowest field in the lowest bits
    typedef struct packed {
        logic [TASK_W-1:0] succ_task;
        logic              succ_valid;
        logic [TASK_W-1:0] pred_task;
        logic              pred_valid;
        logic [TASK_W-1:0] head_task;
    } res_t;

endpackage

`default_nettype wire

[sv/priority_ready_queue_insert.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_ready_queue_insert
// Inserts tasks into a priority-ordered linked-list ready queue.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one insert request per item: task number and its priority.
//   m_* returns one result item per request: the queue head after the
//   insert and the new task's predecessor and successor (with valid flags).
//   The list is ordered by descending priority; equal priorities keep
//   arrival order. The caller must never insert a task already queued.
// Timing:
//   The walk reads one list entry per cycle from the link/priority RAM. An
//   insert walks past queued entries of equal or higher priority, links the
//   predecessor to it (or makes it head), writes its entry, then hands the
//   result to m_*; an empty queue skips the walk. A task number out of range
//   changes nothing and goes straight to the result. s_tready is low for the
//   whole insert and rises in the cycle after the result is handed to m_*.
// Reset:
//   Asynchronous, active low. Empties the queue (head = nil); the RAM
//   contents are not cleared and are only read after being written.
// Stall:
//   The result sits in an output register; the next request is accepted
//   while it waits. A second finished result waits in the sequencer until
//   m_tready frees the output register.
// ----------------------------------------------------------------------------
module priority_ready_queue_insert #(
    parameter int NUM_TASKS  = prq_pkg::NUM_TASKS_DEF,
    parameter int PRIO_WIDTH = prq_pkg::PRIO_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [3:0] task_id, [11:4] task_prio, [15:12] zero
    input  wire logic [prq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [3:0] head_task, [4] pred_valid, [8:5] pred_task, [9] succ_valid,
    // [13:10] succ_task, [15:14] zero
    output logic      [prq_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int RES_W = $bits(prq_pkg::res_t);

    logic                         res_valid;
    logic                         res_ready;
    prq_pkg::res_t                res;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [prq_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    prq_walker #(
        .NUM_TASKS  (NUM_TASKS),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_tid    (s_tdata[prq_pkg::TASK_W-1:0]),
        .in_prio   (s_tdata[prq_pkg::TASK_W +: prq_pkg::IN_PRIO_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: free when empty or being drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = prq_pkg::M_TDATA_W'(res);
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // An accepted request keeps the input closed while it is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // A pending result and an open input never coexist
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !s_tready)
        else $error("input open while result pending");

    // A handed-off result shows up unchanged on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> m_tvalid && (m_tdata[RES_W-1:0] == $past(res)))
        else $error("result lost in output register");

endmodule

`default_nettype wire

[sv/prq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/prq_walker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_walker
// Sequencer that walks the linked list one entry per cycle and links in the
// new task with a table write of its own entry, plus one of its predecessor's link if it has one.
// ----------------------------------------------------------------------------
module prq_walker #(
    parameter int NUM_TASKS  = prq_pkg::NUM_TASKS_DEF,
    parameter int PRIO_WIDTH = prq_pkg::PRIO_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [prq_pkg::TASK_W-1:0]    in_tid,
    input  wire logic [prq_pkg::IN_PRIO_W-1:0] in_prio,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output prq_pkg::res_t                     res
);

    localparam int AW = $clog2(NUM_TASKS);       // table index
    localparam int LW = $clog2(NUM_TASKS + 1);   // link, includes nil
    localparam int SW = $clog2(NUM_TASKS + 1);   // step count
    localparam int EW = LW + PRIO_WIDTH;         // entry: {prio, link}
    localparam logic [LW-1:0] NIL = LW'(NUM_TASKS);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_WALK      = 5'b00010,
        ST_LINK_PRED = 5'b00100,
        ST_LINK_NEW  = 5'b01000,
        ST_DONE      = 5'b10000
    } state_t;

    state_t                      state_reg, state_next;
    logic [prq_pkg::TASK_W-1:0]  tid_reg, tid_next;
    logic [PRIO_WIDTH-1:0]       prio_reg, prio_next;
    logic [LW-1:0]               head_reg, head_next;
    logic [LW-1:0]               cur_reg, cur_next;
    logic [LW-1:0]               prev_reg, prev_next;
    logic                        prev_ok_reg, prev_ok_next;
    logic [PRIO_WIDTH-1:0]       prev_prio_reg, prev_prio_next;
    logic [SW-1:0]               steps_reg, steps_next;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [EW-1:0]               ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [EW-1:0]               ram_rdata;

    logic [LW-1:0]               link_in;
    logic [PRIO_WIDTH-1:0]       prio_in;
    logic                        link_ok;
    logic                        go_on;
    logic                        tid_in_range;

    prq_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_TASKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Compare unit: one entry of the walk per cycle
    assign link_in      = ram_rdata[LW-1:0];
    assign prio_in      = ram_rdata[EW-1:LW];
    assign link_ok      = (link_in < NIL);
    assign go_on        = (steps_reg < SW'(NUM_TASKS)) && (prio_reg <= prio_in);
    assign tid_in_range = (9'(in_tid) < 9'(NUM_TASKS));

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    // Read address: followed link while walking, head in every other state
    always_comb
    begin
        if (state_reg == ST_WALK)
        begin
            ram_raddr = link_in[AW-1:0];
        end
        else
        begin
            ram_raddr = head_reg[AW-1:0];
        end
    end

    always_comb
    begin
        res.head_task  = (head_reg == NIL) ? '0 : prq_pkg::TASK_W'(head_reg);
        res.pred_valid = prev_ok_reg;
        res.pred_task  = prev_ok_reg ? prq_pkg::TASK_W'(prev_reg) : '0;
        res.succ_valid = (cur_reg != NIL);
        res.succ_task  = (cur_reg != NIL) ? prq_pkg::TASK_W'(cur_reg) : '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        tid_next       = tid_reg;
        prio_next      = prio_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        prev_ok_next   = prev_ok_reg;
        prev_prio_next = prev_prio_reg;
        steps_next     = steps_reg;
        ram_we         = 1'b0;
        ram_waddr      = prev_reg[AW-1:0];
        ram_wdata      = {prev_prio_reg, LW'(tid_reg)};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    tid_next     = in_tid;
                    prio_next    = PRIO_WIDTH'(in_prio);
                    steps_next   = '0;
                    prev_ok_next = 1'b0;
                    cur_next     = NIL;
                    if (!tid_in_range)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (head_reg != NIL)
                    begin
                        cur_next   = head_reg;
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_LINK_PRED;
                    end
                end
            end
            ST_WALK:
            begin
                if (go_on)
                begin
                    prev_next      = cur_reg;
                    prev_ok_next   = 1'b1;
                    prev_prio_next = prio_in;
                    steps_next     = steps_reg + 1'b1;
                    cur_next       = link_ok ? link_in : NIL;
                    if (!link_ok)
                    begin
                        state_next = ST_LINK_PRED;
                    end
                end
                else
                begin
                    state_next = ST_LINK_PRED;
                end
            end
            ST_LINK_PRED:
            begin
                // predecessor points at the new task, or it becomes head
                if (prev_ok_reg)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    head_next = LW'(tid_reg);
                end
                state_next = ST_LINK_NEW;
            end
            ST_LINK_NEW:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(tid_reg);
                ram_wdata  = {prio_reg, cur_reg};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= NIL;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg       <= tid_next;
        prio_reg      <= prio_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        prev_ok_reg   <= prev_ok_next;
        prev_prio_reg <= prev_prio_next;
        steps_reg     <= steps_next;
    end

endmodule

`default_nettype wire
